// ===== sv/glyph_atlas_color_render_unit_macros.svh =====
// Assertion macros shared by the glyph atlas color render unit.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef GLYPH_ATLAS_COLOR_RENDER_UNIT_MACROS_SVH
`define GLYPH_ATLAS_COLOR_RENDER_UNIT_MACROS_SVH

// Same-cycle implication.
`define GACRU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GACRU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/gacru_pkg.sv =====
// Types, widths and constants of the glyph atlas color render unit.
// Used by every module of the block but gacru_ram; depends on nothing.
`timescale 1ns / 1ps

package gacru_pkg;

    // Atlas store size and derived address widths.
    localparam int ATLAS_DEPTH = 65536;
    localparam int ADDR_W      = $clog2(ATLAS_DEPTH);
    localparam int SIZE_W      = ADDR_W + 1;

    // Field widths.
    localparam int CODE_W  = 16;
    localparam int DIM_W   = 7;
    localparam int PIX_W   = 6;
    localparam int COLOR_W = 32;
    localparam int LANE_W  = 8;
    localparam int LANES   = 4;
    localparam int GRAY_W  = 8;

    // Address arithmetic widths.
    localparam int PROD_W   = CODE_W + DIM_W;
    localparam int BASE_W   = PIX_W + CODE_W + 1;
    localparam int T3_W     = PROD_W + CODE_W;
    localparam int OFFS_W   = T3_W + 1;
    localparam int ADDR_S_W = OFFS_W + 2;

    // Blend widths.
    localparam int BPROD_W = LANE_W + GRAY_W;

    // Digit-per-stage divider for the glyph index.
    localparam int DIV_STEPS = CODE_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

    // Result queue.
    localparam int RESULT_DEPTH = 32;
    localparam int PTR_W        = $clog2(RESULT_DEPTH);
    localparam int CNT_W        = $clog2(RESULT_DEPTH + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_CODE   = 3'd0,
        CFG_LAST_CODE    = 3'd1,
        CFG_CELL_WIDTH   = 3'd2,
        CFG_CELL_HEIGHT  = 3'd3,
        CFG_ATLAS_WIDTH  = 3'd4,
        CFG_ATLAS_HEIGHT = 3'd5
    } t_cfg_reg;

    typedef enum logic {
        REQ_WRITE  = 1'b0,
        REQ_RENDER = 1'b1
    } t_req;

    // Reset values of the configuration registers.
    localparam logic [CODE_W-1:0] RST_FIRST_CODE   = 16'd32;
    localparam logic [CODE_W-1:0] RST_LAST_CODE    = 16'd255;
    localparam logic [DIM_W-1:0]  RST_CELL_WIDTH   = 7'd12;
    localparam logic [DIM_W-1:0]  RST_CELL_HEIGHT  = 7'd20;
    localparam logic [CODE_W-1:0] RST_ATLAS_WIDTH  = 16'd192;
    localparam logic [CODE_W-1:0] RST_ATLAS_HEIGHT = 16'd300;
    localparam int RST_CPR_INT  = 192 / 12;
    localparam int RST_AREA_INT = 192 * 300;
    localparam int RST_SIZE_INT = (RST_AREA_INT > ATLAS_DEPTH) ? ATLAS_DEPTH : RST_AREA_INT;
    localparam logic [CODE_W-1:0] RST_CPR  = CODE_W'(RST_CPR_INT);
    localparam logic [SIZE_W-1:0] RST_SIZE = SIZE_W'(RST_SIZE_INT);

    // Fill color given for addresses outside the atlas or when there are no cells per row.
    localparam logic [LANE_W-1:0] FILL_LANE0 = 8'hFF;
    localparam logic [LANE_W-1:0] FILL_LANE1 = 8'h00;
    localparam logic [LANE_W-1:0] FILL_LANE2 = 8'h00;
    localparam logic [LANE_W-1:0] FILL_LANE3 = 8'h80;
    localparam logic [LANE_W-1:0] LANE_MAX   = 8'hFF;

    // One input beat.
    typedef struct packed {
        logic                req_type;
        logic [CODE_W-1:0]   atlas_address;
        logic [GRAY_W-1:0]   atlas_data;
        logic [CODE_W-1:0]   char_code;
        logic [PIX_W-1:0]    pixel_x;
        logic [PIX_W-1:0]    pixel_y;
        logic [COLOR_W-1:0]  low_color;
        logic [COLOR_W-1:0]  high_color;
    } t_in_beat;

    // One result beat.
    typedef struct packed {
        logic [LANE_W-1:0] lane0;
        logic [LANE_W-1:0] lane1;
        logic [LANE_W-1:0] lane2;
        logic [LANE_W-1:0] lane3;
        logic              out_of_range;
    } t_out_beat;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [CODE_W-1:0] first_code;
        logic [CODE_W-1:0] last_code;
        logic [DIM_W-1:0]  cell_width;
        logic [DIM_W-1:0]  cell_height;
        logic [CODE_W-1:0] atlas_width;
        logic [CODE_W-1:0] cpr;
        logic              no_cells;
        logic [SIZE_W-1:0] size;
        logic              busy;
    } t_cfg;

    // Fields carried alongside the glyph index divider.
    typedef struct packed {
        logic               req_type;
        logic [CODE_W-1:0]  atlas_address;
        logic [GRAY_W-1:0]  atlas_data;
        logic               neg;
        logic [PIX_W-1:0]   pixel_x;
        logic [PIX_W-1:0]   pixel_y;
        logic [COLOR_W-1:0] low_color;
        logic [COLOR_W-1:0] high_color;
    } t_div_pay;

endpackage

// ===== sv/gacru_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// Stand-alone; holds the grayscale atlas.
`timescale 1ns / 1ps

module gacru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read share the address; read data is registered.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/gacru_cfg.sv =====
// Configuration registers, cells-per-row divider and atlas size.
// Depends on gacru_pkg.
`timescale 1ns / 1ps

module gacru_cfg import gacru_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    logic [CODE_W-1:0] r_first_code;
    logic [CODE_W-1:0] r_last_code;
    logic [DIM_W-1:0]  r_cell_width;
    logic [DIM_W-1:0]  r_cell_height;
    logic [CODE_W-1:0] r_atlas_width;
    logic [CODE_W-1:0] r_atlas_height;
    logic [CODE_W-1:0] r_cpr;
    logic              r_no_cells;
    logic [SIZE_W-1:0] r_size;
    logic              r_start;
    logic              r_running;
    logic [DCNT_W-1:0] r_cnt;
    logic [CODE_W-1:0] r_rem;
    logic [CODE_W-1:0] r_work;

    logic [CODE_W:0]   n_trial;
    logic              n_bit;
    logic [CODE_W-1:0] n_rem;
    logic [CODE_W-1:0] n_work;
    logic [2*CODE_W-1:0] n_area;
    logic [SIZE_W-1:0] n_size;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_code   <= RST_FIRST_CODE;
            r_last_code    <= RST_LAST_CODE;
            r_cell_width   <= RST_CELL_WIDTH;
            r_cell_height  <= RST_CELL_HEIGHT;
            r_atlas_width  <= RST_ATLAS_WIDTH;
            r_atlas_height <= RST_ATLAS_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FIRST_CODE:   r_first_code   <= i_cfg_data;
                CFG_LAST_CODE:    r_last_code    <= i_cfg_data;
                CFG_CELL_WIDTH:   r_cell_width   <= i_cfg_data[DIM_W-1:0];
                CFG_CELL_HEIGHT:  r_cell_height  <= i_cfg_data[DIM_W-1:0];
                CFG_ATLAS_WIDTH:  r_atlas_width  <= i_cfg_data;
                CFG_ATLAS_HEIGHT: r_atlas_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // One restoring step of atlas_width / cell_width per cycle.
    always_comb begin
        n_trial = {r_rem, r_work[CODE_W-1]};
        n_bit   = (n_trial >= {{(CODE_W-DIM_W+1){1'b0}}, r_cell_width});
        n_rem   = n_bit ? CODE_W'(n_trial - {{(CODE_W-DIM_W+1){1'b0}}, r_cell_width})
                        : n_trial[CODE_W-1:0];
        n_work  = {r_work[CODE_W-2:0], n_bit};
    end

    // Divider sequencer; any write restarts it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start    <= 1'b0;
            r_running  <= 1'b0;
            r_cnt      <= '0;
            r_cpr      <= RST_CPR;
            r_no_cells <= 1'b0;
        end else if (i_cfg_we) begin
            r_start   <= 1'b1;
            r_running <= 1'b0;
        end else if (r_start) begin
            r_start   <= 1'b0;
            r_running <= 1'b1;
            r_cnt     <= DCNT_W'(DIV_STEPS);
        end else if (r_running) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DCNT_W'(1)) begin
                r_running  <= 1'b0;
                r_cpr      <= n_work;
                r_no_cells <= (r_cell_width == '0) || (n_work == '0);
            end
        end
    end

    // Datapath registers of the divider.
    always_ff @(posedge i_clk) begin
        if (r_start) begin
            r_rem  <= '0;
            r_work <= r_atlas_width;
        end else begin
            r_rem  <= n_rem;
            r_work <= n_work;
        end
    end

    // Usable atlas size: the smaller of the configured area and the store.
    always_comb begin
        n_area = {{CODE_W{1'b0}}, r_atlas_width} * {{CODE_W{1'b0}}, r_atlas_height};
        n_size = (n_area >= (2*CODE_W)'(ATLAS_DEPTH)) ? SIZE_W'(ATLAS_DEPTH)
                                                     : n_area[SIZE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= RST_SIZE;
        end else begin
            r_size <= n_size;
        end
    end

    always_comb begin
        o_cfg.first_code  = r_first_code;
        o_cfg.last_code   = r_last_code;
        o_cfg.cell_width  = r_cell_width;
        o_cfg.cell_height = r_cell_height;
        o_cfg.atlas_width = r_atlas_width;
        o_cfg.cpr         = r_cpr;
        o_cfg.no_cells    = r_no_cells;
        o_cfg.size        = r_size;
        o_cfg.busy        = r_start || r_running;
    end

endmodule

// ===== sv/gacru_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, side fields ride along.
// Depends on gacru_pkg.
`timescale 1ns / 1ps

module gacru_div import gacru_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [CODE_W-1:0] i_mag,
    input  logic [CODE_W-1:0] i_divisor,
    input  t_div_pay          i_pay,
    output logic              o_valid,
    output logic [CODE_W-1:0] o_quot,
    output logic [CODE_W-1:0] o_rem,
    output t_div_pay          o_pay
);

    logic              r_v    [DIV_STEPS];
    logic [CODE_W-1:0] r_rem  [DIV_STEPS];
    logic [CODE_W-1:0] r_work [DIV_STEPS];
    t_div_pay          r_pay  [DIV_STEPS];

    logic              c_v    [DIV_STEPS];
    logic [CODE_W-1:0] c_rem  [DIV_STEPS];
    logic [CODE_W-1:0] c_work [DIV_STEPS];
    t_div_pay          c_pay  [DIV_STEPS];

    // Stage inputs: the port for the first stage, the previous stage after that.
    always_comb begin
        c_v[0]    = i_valid;
        c_rem[0]  = '0;
        c_work[0] = i_mag;
        c_pay[0]  = i_pay;
        for (int k = 1; k < DIV_STEPS; k++) begin
            c_v[k]    = r_v[k-1];
            c_rem[k]  = r_rem[k-1];
            c_work[k] = r_work[k-1];
            c_pay[k]  = r_pay[k-1];
        end
    end

    // Each stage shifts in one dividend bit and tries one subtraction.
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [CODE_W:0] w_trial;
        logic            w_bit;

        assign w_trial = {c_rem[k], c_work[k][CODE_W-1]};
        assign w_bit   = (w_trial >= {1'b0, i_divisor});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= c_v[k];
            end
            r_pay[k]  <= c_pay[k];
            r_rem[k]  <= w_bit ? CODE_W'(w_trial - {1'b0, i_divisor})
                               : w_trial[CODE_W-1:0];
            r_work[k] <= {c_work[k][CODE_W-2:0], w_bit};
        end
    end

    assign o_valid = r_v[DIV_STEPS-1];
    assign o_quot  = r_work[DIV_STEPS-1];
    assign o_rem   = r_rem[DIV_STEPS-1];
    assign o_pay   = r_pay[DIV_STEPS-1];

endmodule

// ===== sv/gacru_fifo.sv =====
// Result queue between the render pipeline and the output channel.
// Depends on gacru_pkg; never overflows because the top level counts credits.
`timescale 1ns / 1ps

module gacru_fifo import gacru_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_beat i_beat,
    output logic      o_valid,
    output t_out_beat o_beat,
    input  logic      i_stall
);

    t_out_beat        r_mem [RESULT_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             n_pop;

    assign o_valid = (r_count != '0);
    assign o_beat  = r_mem[r_rd];
    assign n_pop   = o_valid && !i_stall;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_beat;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(RESULT_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (n_pop) begin
                r_rd <= (r_rd == PTR_W'(RESULT_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, n_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== sv/glyph_atlas_color_render_unit.sv =====
// Glyph atlas color render unit: top level. Uses gacru_pkg, gacru_cfg, gacru_div,
// gacru_ram, gacru_fifo and the assertion macros header.
// Input channel (i_in_valid / o_in_stall / i_in_beat) carries two kinds of beats:
// an atlas write (req_type 0) stores one gray byte, a render (req_type 1) yields
// exactly one result beat on the output channel (o_out_valid / i_out_stall /
// o_out_beat). Write beats give no result. Beats are handled strictly in order,
// so a render sees every atlas write accepted before it.
// Throughput is one beat per clock when o_in_stall is low. A render passes the
// input register, one clamp stage, the 16-stage glyph index divider, four address
// stages, the atlas RAM read, one blend stage and the result queue write.
// A 32-entry result queue decouples the receiver; a credit count stalls input
// only when the queue could overflow, so a stalled receiver backs up the input
// after at most 32 outstanding renders.
// Configuration writes go through i_cfg_we / i_cfg_index / i_cfg_data while idle.
// Each write starts a cells-per-row division and holds o_in_stall high until it
// finishes. Reset is synchronous: registers take their default values and all
// pipeline and queue state is emptied; the atlas is not cleared and holds
// undefined bytes until written.
`timescale 1ns / 1ps
`include "glyph_atlas_color_render_unit_macros.svh"

module glyph_atlas_color_render_unit import gacru_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_beat              i_in_beat,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_beat             o_out_beat,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg cfg;

    logic w_in_accept;
    logic w_out_accept;
    logic [CNT_W-1:0] r_credits;

    // Stage 1: input register.
    logic     r_s1_v;
    t_in_beat r_s1_beat;

    // Stage 2: clamped glyph offset.
    logic              r_s2_v;
    logic [CODE_W-1:0] r_s2_mag;
    t_div_pay          r_s2_pay;
    logic [CODE_W-1:0] n_clamped;
    logic              n_neg;
    t_div_pay          n_pay;

    // Divider output.
    logic              d_v;
    logic [CODE_W-1:0] d_quot;
    logic [CODE_W-1:0] d_rem;
    t_div_pay          d_pay;

    // Stages 3 to 6: pixel address.
    logic              r_s3_v;
    t_div_pay          r_s3_pay;
    logic [PROD_W-1:0] r_s3_t1;
    logic [PROD_W-1:0] r_s3_t2;
    logic [BASE_W-1:0] r_s3_base;
    logic              r_s4_v;
    t_div_pay          r_s4_pay;
    logic [PROD_W-1:0] r_s4_t1;
    logic [T3_W-1:0]   r_s4_t3;
    logic [BASE_W-1:0] r_s4_base;
    logic              r_s5_v;
    t_div_pay          r_s5_pay;
    logic [OFFS_W-1:0] r_s5_offs;
    logic [BASE_W-1:0] r_s5_base;
    logic signed [ADDR_S_W-1:0] n_addr;
    logic              n_oor;
    logic              n_wr_ok;
    logic              r_s6_v;
    logic              r_s6_req;
    logic              r_s6_wr_ok;
    logic              r_s6_oor;
    logic [ADDR_W-1:0] r_s6_rd_addr;
    logic [CODE_W-1:0] r_s6_wr_addr;
    logic [GRAY_W-1:0] r_s6_wr_data;
    logic [COLOR_W-1:0] r_s6_lo;
    logic [COLOR_W-1:0] r_s6_hi;

    // Atlas RAM port.
    logic              w_ram_we;
    logic [ADDR_W-1:0] w_ram_addr;
    logic [GRAY_W-1:0] w_gray;

    // Stage 7: gray read back; stage 8: blend products.
    logic               r_s7_v;
    logic               r_s7_oor;
    logic [COLOR_W-1:0] r_s7_lo;
    logic [COLOR_W-1:0] r_s7_hi;
    logic [LANE_W-1:0]  n_lo   [LANES];
    logic [LANE_W-1:0]  n_hi   [LANES];
    logic               n_dneg [LANES];
    logic [LANE_W-1:0]  n_dmag [LANES];
    logic               r_s8_v;
    logic               r_s8_oor;
    logic [BPROD_W-1:0] r_s8_prod [LANES];
    logic               r_s8_dneg [LANES];
    logic [LANE_W-1:0]  r_s8_lo   [LANES];

    // Final lanes.
    logic [BPROD_W:0]     n_sum  [LANES];
    logic [LANE_W:0]      n_quo  [LANES];
    logic signed [LANE_W+2:0] n_val [LANES];
    logic [LANE_W-1:0]    n_lane [LANES];
    t_out_beat            n_res;

    // Configuration and cells-per-row.
    gacru_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Input handshake and result credits.
    assign o_in_stall   = cfg.busy || (r_credits == CNT_W'(RESULT_DEPTH));
    assign w_in_accept  = i_in_valid && !o_in_stall;
    assign w_out_accept = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credits <= '0;
        end else begin
            case ({w_in_accept && (i_in_beat.req_type == REQ_RENDER), w_out_accept})
                2'b10:   r_credits <= r_credits + 1'b1;
                2'b01:   r_credits <= r_credits - 1'b1;
                default: r_credits <= r_credits;
            endcase
        end
    end

    // Stage 1.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= w_in_accept;
        end
        if (w_in_accept) begin
            r_s1_beat <= i_in_beat;
        end
    end

    // Clamp the code and take its signed offset from first_code.
    always_comb begin
        if (r_s1_beat.char_code < cfg.first_code) begin
            n_clamped = cfg.first_code;
        end else if (r_s1_beat.char_code > cfg.last_code) begin
            n_clamped = cfg.last_code;
        end else begin
            n_clamped = r_s1_beat.char_code;
        end
        n_neg = (n_clamped < cfg.first_code);
        n_pay.req_type      = r_s1_beat.req_type;
        n_pay.atlas_address = r_s1_beat.atlas_address;
        n_pay.atlas_data    = r_s1_beat.atlas_data;
        n_pay.neg           = n_neg;
        n_pay.pixel_x       = r_s1_beat.pixel_x;
        n_pay.pixel_y       = r_s1_beat.pixel_y;
        n_pay.low_color     = r_s1_beat.low_color;
        n_pay.high_color    = r_s1_beat.high_color;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
        r_s2_pay <= n_pay;
        r_s2_mag <= n_neg ? (cfg.first_code - n_clamped) : (n_clamped - cfg.first_code);
    end

    // Glyph column and row as remainder and quotient of the offset magnitude.
    gacru_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_s2_v),
        .i_mag     (r_s2_mag),
        .i_divisor (cfg.cpr),
        .i_pay     (r_s2_pay),
        .o_valid   (d_v),
        .o_quot    (d_quot),
        .o_rem     (d_rem),
        .o_pay     (d_pay)
    );

    // Stage 3: column * cell_width, row * cell_height, pixel base.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else begin
            r_s3_v <= d_v;
        end
        r_s3_pay  <= d_pay;
        r_s3_t1   <= PROD_W'(d_rem) * PROD_W'(cfg.cell_width);
        r_s3_t2   <= PROD_W'(d_quot) * PROD_W'(cfg.cell_height);
        r_s3_base <= BASE_W'(d_pay.pixel_y) * BASE_W'(cfg.atlas_width)
                   + BASE_W'(d_pay.pixel_x);
    end

    // Stage 4: row offset times the atlas row length.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else begin
            r_s4_v <= r_s3_v;
        end
        r_s4_pay  <= r_s3_pay;
        r_s4_t1   <= r_s3_t1;
        r_s4_t3   <= T3_W'(r_s3_t2) * T3_W'(cfg.atlas_width);
        r_s4_base <= r_s3_base;
    end

    // Stage 5: magnitude of the glyph cell offset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_v <= 1'b0;
        end else begin
            r_s5_v <= r_s4_v;
        end
        r_s5_pay  <= r_s4_pay;
        r_s5_offs <= OFFS_W'(r_s4_t1) + OFFS_W'(r_s4_t3);
        r_s5_base <= r_s4_base;
    end

    // Stage 6: signed pixel address, range check and write address check.
    always_comb begin
        if (r_s5_pay.neg) begin
            n_addr = $signed(ADDR_S_W'(r_s5_base)) - $signed(ADDR_S_W'(r_s5_offs));
        end else begin
            n_addr = $signed(ADDR_S_W'(r_s5_base)) + $signed(ADDR_S_W'(r_s5_offs));
        end
        n_oor = cfg.no_cells || n_addr[ADDR_S_W-1]
             || (n_addr[ADDR_S_W-2:0] >= (ADDR_S_W-1)'(cfg.size));
        n_wr_ok = (32'(r_s5_pay.atlas_address) < 32'(ATLAS_DEPTH));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_v <= 1'b0;
        end else begin
            r_s6_v <= r_s5_v;
        end
        r_s6_req     <= r_s5_pay.req_type;
        r_s6_wr_ok   <= n_wr_ok;
        r_s6_oor     <= n_oor;
        r_s6_rd_addr <= n_addr[ADDR_W-1:0];
        r_s6_wr_addr <= r_s5_pay.atlas_address;
        r_s6_wr_data <= r_s5_pay.atlas_data;
        r_s6_lo      <= r_s5_pay.low_color;
        r_s6_hi      <= r_s5_pay.high_color;
    end

    // Atlas access: writes and reads reach the RAM in beat order.
    assign w_ram_we   = r_s6_v && (r_s6_req == REQ_WRITE) && r_s6_wr_ok;
    assign w_ram_addr = (r_s6_req == REQ_WRITE) ? ADDR_W'(r_s6_wr_addr) : r_s6_rd_addr;

    gacru_ram #(
        .WIDTH (GRAY_W),
        .DEPTH (ATLAS_DEPTH)
    ) u_atlas (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (r_s6_wr_data),
        .o_rdata (w_gray)
    );

    // Stage 7: only renders continue; the gray byte arrives from the RAM.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_v <= 1'b0;
        end else begin
            r_s7_v <= r_s6_v && (r_s6_req == REQ_RENDER);
        end
        r_s7_oor <= r_s6_oor;
        r_s7_lo  <= r_s6_lo;
        r_s7_hi  <= r_s6_hi;
    end

    // Per-lane color difference magnitude and direction.
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            n_lo[k]   = r_s7_lo[k*LANE_W +: LANE_W];
            n_hi[k]   = r_s7_hi[k*LANE_W +: LANE_W];
            n_dneg[k] = (n_hi[k] < n_lo[k]);
            n_dmag[k] = n_dneg[k] ? (n_lo[k] - n_hi[k]) : (n_hi[k] - n_lo[k]);
        end
    end

    // Stage 8: difference times gray.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8_v <= 1'b0;
        end else begin
            r_s8_v <= r_s7_v;
        end
        r_s8_oor <= r_s7_oor;
        for (int k = 0; k < LANES; k++) begin
            r_s8_prod[k] <= BPROD_W'(n_dmag[k]) * BPROD_W'(w_gray);
            r_s8_dneg[k] <= n_dneg[k];
            r_s8_lo[k]   <= n_lo[k];
        end
    end

    // Exact divide by 255 of the byte-by-byte product, then step from the low color.
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            n_sum[k] = (BPROD_W+1)'(r_s8_prod[k]) + (BPROD_W+1)'(r_s8_prod[k] >> LANE_W)
                     + (BPROD_W+1)'(1);
            n_quo[k] = n_sum[k][BPROD_W:LANE_W];
            if (r_s8_dneg[k]) begin
                n_val[k] = $signed((LANE_W+3)'(r_s8_lo[k])) - $signed((LANE_W+3)'(n_quo[k]));
            end else begin
                n_val[k] = $signed((LANE_W+3)'(r_s8_lo[k])) + $signed((LANE_W+3)'(n_quo[k]));
            end
            if (n_val[k] < 0) begin
                n_lane[k] = '0;
            end else if (n_val[k] > $signed((LANE_W+3)'(LANE_MAX))) begin
                n_lane[k] = LANE_MAX;
            end else begin
                n_lane[k] = n_val[k][LANE_W-1:0];
            end
        end
        if (r_s8_oor) begin
            n_res.lane0        = FILL_LANE0;
            n_res.lane1        = FILL_LANE1;
            n_res.lane2        = FILL_LANE2;
            n_res.lane3        = FILL_LANE3;
            n_res.out_of_range = 1'b1;
        end else begin
            n_res.lane0        = n_lane[0];
            n_res.lane1        = n_lane[1];
            n_res.lane2        = n_lane[2];
            n_res.lane3        = n_lane[3];
            n_res.out_of_range = 1'b0;
        end
    end

    // Result queue drives the output channel.
    gacru_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s8_v),
        .i_beat  (n_res),
        .o_valid (o_out_valid),
        .o_beat  (o_out_beat),
        .i_stall (i_out_stall)
    );

    // A finished render always holds a credit taken at acceptance.
    `GACRU_ASSERT_NOW(a_push_has_credit, r_s8_v, r_credits != '0, "result without credit")
    // With no outstanding renders the output channel is empty.
    `GACRU_ASSERT_NOW(a_idle_no_output, r_credits == '0, !o_out_valid, "output without render")
    // A configuration write blocks input while cells-per-row is recomputed.
    `GACRU_ASSERT_NEXT(a_cfg_blocks_input, i_cfg_we, o_in_stall, "input open after config write")

endmodule

// ===== verif/testbench.sv =====
// Self-checking bench for the glyph atlas color render unit: a directed table and random phases.
// Results are checked against an in-bench pixel predictor.
// Depends on gacru_pkg and the glyph_atlas_color_render_unit top level only.
`timescale 1ns / 1ps

module testbench;
    import gacru_pkg::*;

    // Idle margin that lets the pipeline empty before config writes.
    localparam int DRAIN_CYCLES = 32;
    localparam int QUIET_LIMIT  = 2000;

    localparam t_out_beat FILL_PIXEL = {FILL_LANE0, FILL_LANE1, FILL_LANE2, FILL_LANE3, 1'b1};

    typedef struct {
        t_in_beat  beat;
        bit        typed;
        t_out_beat result;
    } t_bench_row;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    t_in_beat              in_beat     = '0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    t_out_beat             out_beat;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    // Shadow copy of the configuration and of the atlas contents.
    logic [CODE_W-1:0] pred_first;
    logic [CODE_W-1:0] pred_last;
    logic [DIM_W-1:0]  pred_cw;
    logic [DIM_W-1:0]  pred_ch;
    logic [CODE_W-1:0] pred_aw;
    logic [CODE_W-1:0] pred_ah;
    logic [GRAY_W-1:0] atlas_copy [ATLAS_DEPTH];
    bit                atlas_loaded [ATLAS_DEPTH];

    t_out_beat  pending_pixels [$];
    t_bench_row bench_rows [$];

    int fail_count   = 0;
    int quiet_cycles = 0;
    int idle_odds    = 6;
    int stall_burst  = 0;
    bit sending      = 1'b0;

    glyph_atlas_color_render_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Atlas byte address of a render, or -1 when the fill color is due.
    function automatic longint pixel_address(input t_in_beat b);
        longint code, first, last, clamped, offs;
        longint cw, ch, aw, ah, cpr, col, row, addr, size;
        code  = b.char_code;
        first = pred_first;
        last  = pred_last;
        cw    = pred_cw;
        ch    = pred_ch;
        aw    = pred_aw;
        ah    = pred_ah;
        if (code < first) clamped = first;
        else if (code > last) clamped = last;
        else clamped = code;
        offs = clamped - first;
        if (cw == 0) return -1;
        cpr = aw / cw;
        if (cpr == 0) return -1;
        // Signed division truncates toward zero, which the inverted code range relies on.
        col  = offs % cpr;
        row  = offs / cpr;
        addr = longint'(b.pixel_x) + col * cw + (longint'(b.pixel_y) + row * ch) * aw;
        size = aw * ah;
        if (size > ATLAS_DEPTH) size = ATLAS_DEPTH;
        if (addr < 0 || addr >= size) return -1;
        return addr;
    endfunction

    // One color lane: lo + trunc((hi - lo) * gray / 255), clamped to a byte.
    function automatic logic [LANE_W-1:0] blend_lane(input logic [7:0] lo, input logic [7:0] hi,
                                                     input logic [7:0] gray);
        int l, h, g, d, mag, q, v;
        l = lo;
        h = hi;
        g = gray;
        d = h - l;
        mag = (d < 0) ? -d : d;
        q = (mag * g) / 255;
        v = l + ((d < 0) ? -q : q);
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    function automatic t_out_beat predict_pixel(input t_in_beat b);
        t_out_beat   r;
        longint      a;
        logic [7:0]  g;
        a = pixel_address(b);
        if (a < 0) return FILL_PIXEL;
        g = atlas_copy[a];
        r.lane0 = blend_lane(b.low_color[7:0],   b.high_color[7:0],   g);
        r.lane1 = blend_lane(b.low_color[15:8],  b.high_color[15:8],  g);
        r.lane2 = blend_lane(b.low_color[23:16], b.high_color[23:16], g);
        r.lane3 = blend_lane(b.low_color[31:24], b.high_color[31:24], g);
        r.out_of_range = 1'b0;
        return r;
    endfunction

    function automatic t_in_beat make_write(input logic [15:0] addr, input logic [7:0] data);
        t_in_beat b;
        b = '0;
        b.req_type      = REQ_WRITE;
        b.atlas_address = addr;
        b.atlas_data    = data;
        return b;
    endfunction

    function automatic t_in_beat make_render(input logic [15:0] code, input logic [5:0] px,
                                             input logic [5:0] py, input logic [31:0] lo,
                                             input logic [31:0] hi);
        t_in_beat b;
        b = '0;
        b.req_type   = REQ_RENDER;
        b.char_code  = code;
        b.pixel_x    = px;
        b.pixel_y    = py;
        b.low_color  = lo;
        b.high_color = hi;
        return b;
    endfunction

    // Random beat; every field is filled so unused ones toggle too.
    function automatic t_in_beat random_beat(input bit render);
        t_in_beat b;
        int       xlim, ylim;
        b.req_type      = render ? REQ_RENDER : REQ_WRITE;
        b.atlas_address = 16'($urandom);
        case ($urandom_range(0, 7))
            0:       b.atlas_data = 8'h00;
            1:       b.atlas_data = 8'hFF;
            default: b.atlas_data = 8'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0: b.char_code = 16'($urandom);
            1: begin
                case ($urandom_range(0, 3))
                    0:       b.char_code = 16'h0000;
                    1:       b.char_code = 16'hFFFF;
                    2:       b.char_code = pred_first;
                    default: b.char_code = pred_last;
                endcase
            end
            default: begin
                if (pred_first <= pred_last)
                    b.char_code = pred_first + 16'($urandom_range(0, pred_last - pred_first));
                else
                    b.char_code = 16'($urandom);
            end
        endcase
        // Mostly stay inside the cell, sometimes use the full pixel range.
        xlim = (pred_cw > 64) ? 64 : int'(pred_cw);
        ylim = (pred_ch > 64) ? 64 : int'(pred_ch);
        if (xlim == 0 || $urandom_range(0, 5) == 0) b.pixel_x = 6'($urandom);
        else b.pixel_x = 6'($urandom_range(0, xlim - 1));
        if (ylim == 0 || $urandom_range(0, 5) == 0) b.pixel_y = 6'($urandom);
        else b.pixel_y = 6'($urandom_range(0, ylim - 1));
        case ($urandom_range(0, 5))
            0: begin
                b.low_color  = 32'h0000_0000;
                b.high_color = 32'hFFFF_FFFF;
            end
            1: begin
                b.low_color  = 32'hFFFF_FFFF;
                b.high_color = 32'h0000_0000;
            end
            default: begin
                b.low_color  = $urandom;
                b.high_color = $urandom;
            end
        endcase
        return b;
    endfunction

    // Append one row to the directed table.
    task automatic add_row(input t_in_beat b, input bit typed, input t_out_beat result);
        t_bench_row r;
        r.beat   = b;
        r.typed  = typed;
        r.result = result;
        bench_rows.insert(bench_rows.size(), r);
    endtask

    // Drive one input beat, with an optional gap, and hold it until accepted.
    task automatic send_beat(input t_in_beat b, input bit typed, input t_out_beat result);
        if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
            if (sending) in_valid <= 1'b0;
            sending = 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        sending  = 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (b.req_type == REQ_WRITE) begin
            atlas_copy[b.atlas_address]   = b.atlas_data;
            atlas_loaded[b.atlas_address] = 1'b1;
        end else begin
            pending_pixels.insert(pending_pixels.size(), typed ? result : predict_pixel(b));
        end
    endtask

    // A render preceded by an atlas write whenever its byte is still unknown or a refresh is asked for.
    task automatic send_render(input t_in_beat b, input bit refresh, input bit typed,
                               input t_out_beat result);
        longint   a;
        t_in_beat w;
        a = pixel_address(b);
        if (a >= 0 && (refresh || !atlas_loaded[a])) begin
            w = random_beat(1'b0);
            w.atlas_address = a[15:0];
            send_beat(w, 1'b0, '0);
        end
        send_beat(b, typed, result);
    endtask

    task automatic go_quiet();
        if (sending) in_valid <= 1'b0;
        sending = 1'b0;
    endtask

    task automatic pause_for_results();
        go_quiet();
        do @(posedge clk); while (pending_pixels.size() != 0);
    endtask

    // Write beats give no result, so let the pipeline empty before touching registers.
    task automatic drain_pipeline();
        pause_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_FIRST_CODE:   pred_first = val;
            CFG_LAST_CODE:    pred_last  = val;
            CFG_CELL_WIDTH:   pred_cw    = val[DIM_W-1:0];
            CFG_CELL_HEIGHT:  pred_ch    = val[DIM_W-1:0];
            CFG_ATLAS_WIDTH:  pred_aw    = val;
            CFG_ATLAS_HEIGHT: pred_ah    = val;
            default: ;
        endcase
        cfg_we <= 1'b0;
        // The cells-per-row division keeps the input stalled for a while.
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic apply_config(input logic [15:0] fc, input logic [15:0] lc,
                                input logic [15:0] cw, input logic [15:0] ch,
                                input logic [15:0] aw, input logic [15:0] ah);
        drain_pipeline();
        write_reg(CFG_FIRST_CODE,   fc);
        write_reg(CFG_LAST_CODE,    lc);
        write_reg(CFG_CELL_WIDTH,   cw);
        write_reg(CFG_CELL_HEIGHT,  ch);
        write_reg(CFG_ATLAS_WIDTH,  aw);
        write_reg(CFG_ATLAS_HEIGHT, ah);
    endtask

    task automatic random_config(input bit wide);
        logic [15:0] fc, lc, cw, ch, aw, ah;
        cw = 16'($urandom_range(1, 64));
        ch = 16'($urandom_range(1, 64));
        if (wide) begin
            fc = 16'($urandom);
            lc = 16'($urandom);
            aw = 16'($urandom_range(1, 65535));
            ah = 16'($urandom_range(1, 65535));
        end else begin
            fc = 16'($urandom_range(0, 400));
            lc = fc + 16'($urandom_range(0, 600));
            aw = 16'($urandom_range(cw, 1024));
            ah = 16'($urandom_range(1, 300));
        end
        apply_config(fc, lc, cw, ch, aw, ah);
    endtask

    // Mostly renders on loaded bytes, some fresh rewrites, some stray writes.
    task automatic run_phase(input int renders);
        int pick;
        for (int n = 0; n < renders; n++) begin
            if (n == renders / 2) pause_for_results();
            pick = $urandom_range(0, 9);
            if (pick < 2) send_beat(random_beat(1'b0), 1'b0, '0);
            else send_render(random_beat(1'b1), pick < 4, 1'b0, '0);
        end
    endtask

    // Sample both handshakes, check results and drive the receiver stall.
    always @(posedge clk) begin : result_check
        t_out_beat want;
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet_cycles = 0;
        else quiet_cycles++;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_pixels.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected pixel beat: %h %h %h %h oor %b", out_beat.lane0,
                             out_beat.lane1, out_beat.lane2, out_beat.lane3,
                             out_beat.out_of_range);
            end else begin
                want = pending_pixels.pop_front();
                if (out_beat.lane0 !== want.lane0 || out_beat.lane1 !== want.lane1 ||
                    out_beat.lane2 !== want.lane2 || out_beat.lane3 !== want.lane3 ||
                    out_beat.out_of_range !== want.out_of_range) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("pixel mismatch: expected %h %h %h %h oor %b, got %h %h %h %h oor %b",
                                 want.lane0, want.lane1, want.lane2, want.lane3,
                                 want.out_of_range, out_beat.lane0, out_beat.lane1,
                                 out_beat.lane2, out_beat.lane3, out_beat.out_of_range);
                end
            end
        end
        if (stall_burst > 0) begin
            stall_burst--;
            out_stall <= 1'b1;
        end else if (idle_odds != 0 && $urandom_range(0, idle_odds * 2) == 0) begin
            stall_burst = $urandom_range(1, 18) - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        t_bench_row row;

        pred_first = RST_FIRST_CODE;
        pred_last  = RST_LAST_CODE;
        pred_cw    = RST_CELL_WIDTH;
        pred_ch    = RST_CELL_HEIGHT;
        pred_aw    = RST_ATLAS_WIDTH;
        pred_ah    = RST_ATLAS_HEIGHT;

        // Directed rows at the reset configuration: 16 cells per row, 57600 bytes in use.
        add_row(make_write(16'd0, 8'hFF), 1'b0, '0);
        add_row(make_render(16'd32, 6'd0, 6'd0, 32'h0000_0000, 32'hFFFF_FFFF),
                1'b1, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0});
        add_row(make_write(16'd0, 8'h00), 1'b0, '0);
        add_row(make_render(16'd32, 6'd0, 6'd0, 32'h1234_5678, 32'hFFFF_FFFF),
                1'b1, {8'h78, 8'h56, 8'h34, 8'h12, 1'b0});
        // A code below the first one clamps to it.
        add_row(make_render(16'd0, 6'd0, 6'd0, 32'hFFFF_FFFF, 32'h0000_0000),
                1'b1, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0});
        // Top code, far corner: past the atlas size.
        add_row(make_render(16'hFFFF, 6'd63, 6'd63, 32'h0, 32'hFFFF_FFFF),
                1'b1, FILL_PIXEL);
        add_row(make_write(16'd50100, 8'h80), 1'b0, '0);
        add_row(make_render(16'hFFFF, 6'd0, 6'd0, 32'h0, 32'hFFFF_FFFF), 1'b0, '0);
        add_row(make_render(16'd255, 6'd0, 6'd0, 32'hFFFF_FFFF, 32'h0), 1'b0, '0);
        add_row(make_write(16'hFFFF, 8'hAA), 1'b0, '0);
        add_row(make_write(16'd25, 8'h7F), 1'b0, '0);
        // Pixels at or beyond the cell size are used as given.
        add_row(make_render(16'd33, 6'd13, 6'd0, 32'h00FF_00FF, 32'hFF00_FF00), 1'b0, '0);
        add_row(make_render(16'd33, 6'd63, 6'd0, 32'h8080_8080, 32'h7F7F_7F7F), 1'b0, '0);
        add_row(make_render(16'd32, 6'd0, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0, '0);
        add_row(make_render(16'd100, 6'd11, 6'd19, 32'h0, 32'hFFFF_FFFF), 1'b0, '0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (bench_rows[i]) begin
            row = bench_rows[i];
            if (row.beat.req_type == REQ_RENDER) send_render(row.beat, 1'b0, row.typed, row.result);
            else send_beat(row.beat, 1'b0, '0);
        end

        // Register extremes: one-pixel cells in the widest atlas.
        apply_config(16'h0000, 16'hFFFF, 16'd1, 16'd1, 16'hFFFF, 16'hFFFF);
        run_phase(30);
        apply_config(16'h1000, 16'h1010, 16'd64, 16'd64, 16'd256, 16'd256);
        run_phase(24);
        // Inverted code range gives negative glyph offsets.
        apply_config(16'd300, 16'd100, 16'd12, 16'd1, 16'd192, 16'd300);
        run_phase(24);
        // No cells per row: zero cell width, then a cell wider than the row.
        apply_config(16'd32, 16'd255, 16'd0, 16'd20, 16'd192, 16'd300);
        run_phase(10);
        apply_config(16'd32, 16'd255, 16'd64, 16'd20, 16'd10, 16'd300);
        run_phase(10);

        repeat (4) begin
            idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
            random_config(1'b0);
            run_phase(24);
        end
        random_config(1'b1);
        run_phase(18);

        // Last stretch runs without idling on either side.
        idle_odds = 0;
        apply_config(RST_FIRST_CODE, RST_LAST_CODE, 16'(RST_CELL_WIDTH), 16'(RST_CELL_HEIGHT),
                     RST_ATLAS_WIDTH, RST_ATLAS_HEIGHT);
        run_phase(30);

        drain_pipeline();
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
